/* rtl/trace_amplitude_stats_with_gaps_assert.svh */
// ----------------------------------------------------------------------------
// Trace amplitude statistics: assertion macros
// Shared immediate-style wrappers around concurrent assertions, clocked on
// the rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TRACE_AMPLITUDE_STATS_WITH_GAPS_ASSERT_SVH
`define TRACE_AMPLITUDE_STATS_WITH_GAPS_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TASG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tasg: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define TASG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tasg: next-cycle check failed");

`endif

/* rtl/tasg_pkg.sv */
// ----------------------------------------------------------------------------
// tasg_pkg
// Types, codes and default sizes shared by the trace amplitude statistics
// block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tasg_pkg;

    // Default sizes
    localparam int MAX_GAPS_DEF    = 16;
    localparam int INDEX_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int ALU_BITS_DEF    = SAMPLE_BITS_DEF + INDEX_BITS_DEF + 2;

    // Action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]         action;
        logic [23:0]        gap_start;
        logic [23:0]        gap_end;
        logic signed [31:0] sample_value;
        logic               last;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic signed [31:0] mean_value;
        logic [31:0]        spread;
        logic               mean_invalid;
    } out_word_t;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Adder status
    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flags_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_TEST,
        S_GAPLEN,
        S_EXCL,
        S_SUM,
        S_MAX,
        S_MIN,
        S_INDEX,
        S_DIVISOR,
        S_ABS,
        S_DIVIDE,
        S_SIGN,
        S_SPREAD,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/tasg_ram.sv */
// ----------------------------------------------------------------------------
// tasg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tasg_ram #(
    parameter int WIDTH     = 48,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/tasg_alu.sv */
// ----------------------------------------------------------------------------
// tasg_alu
// Shared signed adder/subtractor with sign and zero status; the data-path sums,
// sample and index compares and divide steps of the block go through it.
// ----------------------------------------------------------------------------
`default_nettype none

module tasg_alu #(
    parameter int WIDTH = tasg_pkg::ALU_BITS_DEF
) (
    input  tasg_pkg::alu_op_t       op,
    input  logic signed [WIDTH-1:0] a,
    input  logic signed [WIDTH-1:0] b,
    output logic signed [WIDTH-1:0] result,
    output tasg_pkg::alu_flags_t    flags
);

    import tasg_pkg::*;

    // Operands are sized so the difference never overflows
    always_comb
    begin
        if (op == ALU_SUB)
        begin
            result = a - b;
        end
        else
        begin
            result = a + b;
        end
        flags.neg  = result[WIDTH-1];
        flags.zero = (result == '0);
    end

endmodule

`default_nettype wire

/* rtl/trace_amplitude_stats_with_gaps.sv */
// ----------------------------------------------------------------------------
// trace_amplitude_stats_with_gaps
// Running max, min, spread and mean of a sample trace with excluded gaps.
// ----------------------------------------------------------------------------
// A trace is a clear word, then up to MAX_GAPS append words carrying sorted
// gap ranges, then sample words in index order; the sample marked last yields
// one result word. Clear and append words leave the block ready; a sample
// word keeps it busy for a gap-table read and then add and compare steps
// on the single shared adder (S_TEST, S_INDEX while skipping a gap; S_TEST,
// S_GAPLEN, S_EXCL, S_INDEX when a gap starts; S_TEST, S_SUM, S_MAX, S_MIN
// unless a new max is taken, S_INDEX for an included sample, with S_GAPLEN
// after S_TEST when an empty gap is consumed first). Once the index range is
// used up a sample word leaves the block ready, and the last one goes on to
// the mean: a restoring division that produces one quotient bit per cycle on
// the same adder; with a divisor not positive it is flagged invalid. The
// finished result sits in an output register, so the next trace can start
// while it waits; a new result stalls only while the previous one is unread.
// ----------------------------------------------------------------------------
`default_nettype none

module trace_amplitude_stats_with_gaps #(
    parameter int MAX_GAPS    = tasg_pkg::MAX_GAPS_DEF,
    parameter int INDEX_BITS  = tasg_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = tasg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tasg_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output tasg_pkg::out_word_t result
);

    import tasg_pkg::*;

    localparam int CNT_BITS  = $clog2(MAX_GAPS + 1);
    localparam int ADDR_BITS = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
    localparam int IDX_BITS  = INDEX_BITS + 1;
    localparam int EXCL_BITS = INDEX_BITS + CNT_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + INDEX_BITS;
    localparam int ALU_BITS  = SUM_BITS + 2;
    localparam int STEP_BITS = $clog2(SUM_BITS);

    // Sequencer and trace state
    state_t                        state_reg, state_next;
    logic [CNT_BITS-1:0]           gap_count_reg, gap_count_next;
    logic [CNT_BITS-1:0]           gap_ptr_reg, gap_ptr_next;
    logic [IDX_BITS-1:0]           index_reg, index_next;
    logic [INDEX_BITS-1:0]         skip_until_reg, skip_until_next;
    logic                          skipping_reg, skipping_next;
    logic [EXCL_BITS-1:0]          excl_reg, excl_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic                          result_valid_reg, result_valid_next;

    // Working registers
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                          last_reg, last_next;
    logic [IDX_BITS-1:0]           tmp_reg, tmp_next;
    logic [IDX_BITS-1:0]           rem_reg, rem_next;
    logic [SUM_BITS-1:0]           quo_reg, quo_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          neg_reg, neg_next;
    logic                          invalid_reg, invalid_next;
    logic signed [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [31:0]                   spread_reg, spread_next;
    out_word_t                     result_reg, result_next;

    // Gap table and shared adder
    logic                          ram_we;
    logic [2*INDEX_BITS-1:0]       ram_wdata;
    logic [2*INDEX_BITS-1:0]       ram_rdata;
    logic [INDEX_BITS-1:0]         gap_lo;
    logic [INDEX_BITS-1:0]         gap_hi;
    alu_op_t                       alu_op;
    logic signed [ALU_BITS-1:0]    alu_a;
    logic signed [ALU_BITS-1:0]    alu_b;
    logic signed [ALU_BITS-1:0]    alu_result;
    alu_flags_t                    alu_flags;
    logic                          alu_pos;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [IDX_BITS:0]             trial;
    logic signed [ALU_BITS-1:0]    quot_signed;
    logic [ALU_BITS-SAMPLE_BITS:0] quot_high;

    tasg_ram #(
        .WIDTH     (2 * INDEX_BITS),
        .DEPTH     (MAX_GAPS),
        .ADDR_BITS (ADDR_BITS)
    ) u_gap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (gap_count_reg[ADDR_BITS-1:0]),
        .wdata (ram_wdata),
        .raddr (gap_ptr_reg[ADDR_BITS-1:0]),
        .rdata (ram_rdata)
    );

    tasg_alu #(
        .WIDTH (ALU_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .flags  (alu_flags)
    );

    assign gap_lo      = ram_rdata[INDEX_BITS-1:0];
    assign gap_hi      = ram_rdata[2*INDEX_BITS-1:INDEX_BITS];
    assign ram_wdata   = {INDEX_BITS'(item.gap_end), INDEX_BITS'(item.gap_start)};
    assign sample_in   = SAMPLE_BITS'(item.sample_value);
    assign alu_pos     = !alu_flags.neg && !alu_flags.zero;
    assign trial       = {rem_reg, quo_reg[SUM_BITS-1]};
    assign quot_signed = neg_reg ? alu_result : ALU_BITS'(quo_reg);
    assign quot_high   = quot_signed[ALU_BITS-1:SAMPLE_BITS-1];

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Operand select for the shared adder
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_TEST:
            begin
                alu_a = ALU_BITS'(index_reg);
                alu_b = skipping_reg ? ALU_BITS'(skip_until_reg) : ALU_BITS'(gap_lo);
            end
            S_GAPLEN:
            begin
                alu_a = ALU_BITS'(gap_hi);
                alu_b = ALU_BITS'(gap_lo);
            end
            S_EXCL:
            begin
                alu_op = ALU_ADD;
                alu_a  = ALU_BITS'(excl_reg);
                alu_b  = ALU_BITS'(tmp_reg);
            end
            S_SUM:
            begin
                alu_op = ALU_ADD;
                alu_a  = ALU_BITS'(sum_reg);
                alu_b  = ALU_BITS'(val_reg);
            end
            S_MAX:
            begin
                alu_a = ALU_BITS'(val_reg);
                alu_b = ALU_BITS'(max_reg);
            end
            S_MIN:
            begin
                alu_a = ALU_BITS'(val_reg);
                alu_b = ALU_BITS'(min_reg);
            end
            S_INDEX:
            begin
                alu_op = ALU_ADD;
                alu_a  = ALU_BITS'(index_reg);
                alu_b  = ALU_BITS'(1);
            end
            S_DIVISOR:
            begin
                alu_a = ALU_BITS'(index_reg);
                alu_b = ALU_BITS'(excl_reg);
            end
            S_ABS:
            begin
                alu_b = ALU_BITS'(sum_reg);
            end
            S_DIVIDE:
            begin
                alu_a = ALU_BITS'(trial);
                alu_b = ALU_BITS'(tmp_reg);
            end
            S_SIGN:
            begin
                alu_b = ALU_BITS'(quo_reg);
            end
            S_SPREAD:
            begin
                alu_a = ALU_BITS'(max_reg);
                alu_b = ALU_BITS'(min_reg);
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next        = state_reg;
        gap_count_next    = gap_count_reg;
        gap_ptr_next      = gap_ptr_reg;
        index_next        = index_reg;
        skip_until_next   = skip_until_reg;
        skipping_next     = skipping_reg;
        excl_next         = excl_reg;
        sum_next          = sum_reg;
        max_next          = max_reg;
        min_next          = min_reg;
        result_valid_next = result_valid_reg;
        val_next          = val_reg;
        last_next         = last_reg;
        tmp_next          = tmp_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        neg_next          = neg_reg;
        invalid_next      = invalid_reg;
        mean_next         = mean_reg;
        spread_next       = spread_reg;
        result_next       = result_reg;
        ram_we            = 1'b0;

        // Output register drains independently of the sequencer
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.action)
                        ACT_CLEAR:
                        begin
                            gap_count_next  = '0;
                            gap_ptr_next    = '0;
                            index_next      = '0;
                            skip_until_next = '0;
                            skipping_next   = 1'b0;
                            excl_next       = '0;
                            sum_next        = '0;
                            max_next        = '0;
                            min_next        = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (gap_count_reg < CNT_BITS'(MAX_GAPS))
                            begin
                                ram_we         = 1'b1;
                                gap_count_next = gap_count_reg + 1'b1;
                            end
                        end
                        ACT_SAMPLE:
                        begin
                            val_next  = sample_in;
                            last_next = item.last;
                            if (index_reg[IDX_BITS-1])
                            begin
                                // index range used up: only report
                                if (item.last)
                                begin
                                    state_next = S_DIVISOR;
                                end
                            end
                            else
                            begin
                                // sample zero seeds max and min
                                if (index_reg == '0)
                                begin
                                    max_next = sample_in;
                                    min_next = sample_in;
                                end
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (skipping_reg)
                begin
                    if (alu_flags.neg)
                    begin
                        state_next = S_INDEX;
                    end
                    else
                    begin
                        skipping_next = 1'b0;
                        state_next    = S_SUM;
                    end
                end
                else if ((gap_ptr_reg < gap_count_reg) && alu_flags.zero)
                begin
                    state_next = S_GAPLEN;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_GAPLEN:
            begin
                gap_ptr_next = gap_ptr_reg + 1'b1;
                if (alu_pos)
                begin
                    tmp_next        = IDX_BITS'(alu_result);
                    skip_until_next = gap_hi;
                    skipping_next   = 1'b1;
                    state_next      = S_EXCL;
                end
                else
                begin
                    // empty or reversed gap: sample is taken
                    state_next = S_SUM;
                end
            end
            S_EXCL:
            begin
                excl_next  = EXCL_BITS'(alu_result);
                state_next = S_INDEX;
            end
            S_SUM:
            begin
                sum_next   = SUM_BITS'(alu_result);
                state_next = S_MAX;
            end
            S_MAX:
            begin
                if (alu_pos)
                begin
                    max_next   = val_reg;
                    state_next = S_INDEX;
                end
                else
                begin
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                if (alu_flags.neg)
                begin
                    min_next = val_reg;
                end
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                index_next = IDX_BITS'(alu_result);
                state_next = last_reg ? S_DIVISOR : S_IDLE;
            end
            S_DIVISOR:
            begin
                if (alu_pos)
                begin
                    tmp_next     = IDX_BITS'(alu_result);
                    invalid_next = 1'b0;
                    state_next   = S_ABS;
                end
                else
                begin
                    invalid_next = 1'b1;
                    mean_next    = '0;
                    state_next   = S_SPREAD;
                end
            end
            S_ABS:
            begin
                neg_next   = sum_reg[SUM_BITS-1];
                quo_next   = sum_reg[SUM_BITS-1] ? SUM_BITS'(alu_result) : SUM_BITS'(sum_reg);
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                // one restoring step per cycle, quotient shifts in at the bottom
                rem_next  = alu_flags.neg ? trial[IDX_BITS-1:0] : IDX_BITS'(alu_result);
                quo_next  = {quo_reg[SUM_BITS-2:0], !alu_flags.neg};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                // restore sign, saturate to the sample range
                if ((&quot_high) || !(|quot_high))
                begin
                    mean_next = quot_signed[SAMPLE_BITS-1:0];
                end
                else if (quot_signed[ALU_BITS-1])
                begin
                    mean_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                end
                else
                begin
                    mean_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                end
                state_next = S_SPREAD;
            end
            S_SPREAD:
            begin
                spread_next = 32'(alu_result);
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.max_value    = 32'(max_reg);
                    result_next.min_value    = 32'(min_reg);
                    result_next.mean_value   = 32'(mean_reg);
                    result_next.spread       = spread_reg;
                    result_next.mean_invalid = invalid_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and trace state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            gap_count_reg    <= '0;
            gap_ptr_reg      <= '0;
            index_reg        <= '0;
            skip_until_reg   <= '0;
            skipping_reg     <= 1'b0;
            excl_reg         <= '0;
            sum_reg          <= '0;
            max_reg          <= '0;
            min_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            gap_count_reg    <= gap_count_next;
            gap_ptr_reg      <= gap_ptr_next;
            index_reg        <= index_next;
            skip_until_reg   <= skip_until_next;
            skipping_reg     <= skipping_next;
            excl_reg         <= excl_next;
            sum_reg          <= sum_next;
            max_reg          <= max_next;
            min_reg          <= min_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        last_reg    <= last_next;
        tmp_reg     <= tmp_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        neg_reg     <= neg_next;
        invalid_reg <= invalid_next;
        mean_reg    <= mean_next;
        spread_reg  <= spread_next;
        result_reg  <= result_next;
    end

endmodule

`default_nettype wire

/* rtl/tasg_checker.sv */
// ----------------------------------------------------------------------------
// tasg_checker
// Port-level checks on the trace amplitude statistics block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trace_amplitude_stats_with_gaps_assert.svh"

module tasg_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input tasg_pkg::in_word_t  item,
    input logic                result_valid,
    input logic                result_ready,
    input tasg_pkg::out_word_t result
);

    import tasg_pkg::*;

    // A stalled result word holds
    `TASG_ASSERT_NEXT(a_result_hold, clk, rst_n,
        result_valid && !result_ready, result_valid && $stable(result))

    // Spread is max minus min
    `TASG_ASSERT_IMPL(a_spread, clk, rst_n,
        result_valid, result.spread == 32'(result.max_value - result.min_value))

    // Max never falls below min
    `TASG_ASSERT_IMPL(a_order, clk, rst_n,
        result_valid, result.max_value >= result.min_value)

    // Flagged mean reads as zero
    `TASG_ASSERT_IMPL(a_invalid_mean, clk, rst_n,
        result_valid && result.mean_invalid, result.mean_value == 32'sd0)

    // Words other than samples leave the block ready again in the next cycle
    `TASG_ASSERT_NEXT(a_ctrl_one_cycle, clk, rst_n,
        item_valid && item_ready && (item.action != ACT_SAMPLE), item_ready)

endmodule

bind trace_amplitude_stats_with_gaps tasg_checker u_tasg_checker (.*);

`default_nettype wire
